// File: src/usd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types and codes of the decoder front end, queue and back end.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int CP_WIDTH    = 31;
    localparam int BYTE_WIDTH  = 8;
    localparam int COUNT_WIDTH = 3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEAD  = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    // One classified byte as the front end hands it to the back end.
    typedef struct packed {
        logic                   is_lf;      // 0x0A
        logic                   is_term;    // 0x0D or 0x00
        logic [COUNT_WIDTH-1:0] lead_len;   // 0 for an invalid lead byte
        logic [6:0]             lead_bits;  // value bits of a lead byte
        logic [5:0]             cont_bits;  // low six bits as a continuation
    } byte_class_t;

    localparam logic [BYTE_WIDTH-1:0] BYTE_LF  = 8'h0A;
    localparam logic [BYTE_WIDTH-1:0] BYTE_CR  = 8'h0D;
    localparam logic [BYTE_WIDTH-1:0] BYTE_NUL = 8'h00;

endpackage

// File: src/usd_if.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder channels
// Valid/ready channels for the input bytes and the decoded characters.
// ----------------------------------------------------------------------------
interface usd_in_if
    import usd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [BYTE_WIDTH-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface usd_out_if
    import usd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CP_WIDTH-1:0]    code_point;
    logic [COUNT_WIDTH-1:0] byte_count;
    logic                   first_in_word;
    logic [1:0]             status;

    modport source (output valid, output code_point, output byte_count,
                    output first_in_word, output status, input ready);
    modport sink   (input valid, input code_point, input byte_count,
                    input first_in_word, input status, output ready);
endinterface

// File: src/usd_front.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder front end
// Accepts raw bytes and classifies them into line ends, lead lengths and
// value bits, then pushes the result into the queue.
// ----------------------------------------------------------------------------
module usd_front
    import usd_pkg::*;
(
    usd_in_if.sink      in_ch,
    output byte_class_t push_data,
    output logic        push_valid,
    input  logic        push_ready
);

    logic [BYTE_WIDTH-1:0] b;

    assign b          = in_ch.data_byte;
    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;

    always_comb
    begin
        push_data.is_lf     = (b == BYTE_LF);
        push_data.is_term   = (b == BYTE_CR) || (b == BYTE_NUL);
        push_data.cont_bits = b[5:0];
        priority if (b[7] == 1'b0)
        begin
            push_data.lead_len  = 3'd1;
            push_data.lead_bits = b[6:0];
        end
        else if (b[7:5] == 3'b110)
        begin
            push_data.lead_len  = 3'd2;
            push_data.lead_bits = {2'b00, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            push_data.lead_len  = 3'd3;
            push_data.lead_bits = {3'b000, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            push_data.lead_len  = 3'd4;
            push_data.lead_bits = {4'b0000, b[2:0]};
        end
        else if (b[7:2] == 6'b111110)
        begin
            push_data.lead_len  = 3'd5;
            push_data.lead_bits = {5'b00000, b[1:0]};
        end
        else if (b[7:1] == 7'b1111110)
        begin
            push_data.lead_len  = 3'd6;
            push_data.lead_bits = {6'b000000, b[0]};
        end
        else
        begin
            push_data.lead_len  = 3'd0;
            push_data.lead_bits = 7'd0;
        end
    end

endmodule

// File: src/usd_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder queue
// Two-entry queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module usd_queue
    import usd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  byte_class_t push_data,
    input  logic        push_valid,
    output logic        push_ready,
    output byte_class_t pop_data,
    output logic        pop_valid,
    input  logic        pop_ready
);

    byte_class_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/usd_back.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder back end
// Holds the pending character, folds in continuation bytes and drives the
// output register with completed, invalid and truncated characters.
// ----------------------------------------------------------------------------
module usd_back
    import usd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  byte_class_t  pop_data,
    input  logic         pop_valid,
    output logic         pop_ready,
    usd_out_if.source    out_ch
);

    logic [COUNT_WIDTH-1:0] left_reg, left_next;
    logic [COUNT_WIDTH-1:0] seq_reg, seq_next;
    logic [CP_WIDTH-1:0]    partial_reg, partial_next;
    logic                   word_start_reg, word_start_next;

    logic                   out_valid_reg;
    logic [CP_WIDTH-1:0]    out_cp_reg, out_cp_next;
    logic [COUNT_WIDTH-1:0] out_cnt_reg, out_cnt_next;
    logic                   out_first_reg;
    status_t                out_st_reg, out_st_next;

    logic                   emit;
    logic                   take;
    logic [CP_WIDTH-1:0]    shifted;
    logic [COUNT_WIDTH-1:0] left_dec;

    // The output slot is free when empty or being drained this cycle.
    assign pop_ready = !out_valid_reg || out_ch.ready;
    assign take      = pop_valid && pop_ready;
    assign shifted   = {partial_reg[CP_WIDTH-7:0], pop_data.cont_bits};
    assign left_dec  = left_reg - 3'd1;

    always_comb
    begin
        left_next       = left_reg;
        seq_next        = seq_reg;
        partial_next    = partial_reg;
        word_start_next = word_start_reg;
        emit            = 1'b0;
        out_cp_next     = '0;
        out_cnt_next    = 3'd1;
        out_st_next     = ST_OK;
        if (left_reg == 3'd0)
        begin
            priority if (pop_data.is_lf || pop_data.is_term)
            begin
                word_start_next = 1'b1;
            end
            else if (pop_data.lead_len == 3'd0)
            begin
                emit            = 1'b1;
                out_st_next     = ST_BAD_LEAD;
                word_start_next = 1'b0;
            end
            else if (pop_data.lead_len == 3'd1)
            begin
                emit            = 1'b1;
                out_cp_next     = {{(CP_WIDTH-7){1'b0}}, pop_data.lead_bits};
                word_start_next = 1'b0;
            end
            else
            begin
                partial_next = {{(CP_WIDTH-7){1'b0}}, pop_data.lead_bits};
                seq_next     = pop_data.lead_len;
                left_next    = pop_data.lead_len - 3'd1;
            end
        end
        else if (pop_data.is_lf)
        begin
            // A line feed abandons the pending character.
            emit            = 1'b1;
            out_cnt_next    = seq_reg - left_reg;
            out_st_next     = ST_TRUNCATED;
            left_next       = 3'd0;
            seq_next        = 3'd0;
            partial_next    = '0;
            word_start_next = 1'b1;
        end
        else
        begin
            left_next    = left_dec;
            partial_next = shifted;
            if (left_dec == 3'd0)
            begin
                emit            = 1'b1;
                out_cp_next     = shifted;
                out_cnt_next    = seq_reg;
                word_start_next = 1'b0;
                partial_next    = '0;
                seq_next        = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= 3'd0;
            seq_reg        <= 3'd0;
            partial_reg    <= '0;
            word_start_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                left_reg       <= left_next;
                seq_reg        <= seq_next;
                partial_reg    <= partial_next;
                word_start_reg <= word_start_next;
            end
            if (pop_ready)
            begin
                out_valid_reg <= take && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_cp_reg    <= out_cp_next;
            out_cnt_reg   <= out_cnt_next;
            out_first_reg <= word_start_reg;
            out_st_reg    <= out_st_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.code_point    = out_cp_reg;
    assign out_ch.byte_count    = out_cnt_reg;
    assign out_ch.first_in_word = out_first_reg;
    assign out_ch.status        = out_st_reg;

endmodule

// File: src/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder top level
// Decodes one to six byte UTF-8 sequences into 31-bit code points.
// Path: bytes pass through the two-entry queue; each result is held in the back end's output register.
// Throughput: one byte per cycle while the output channel does not stall.
// Reset: rst_n empties the queue and pending character and marks a word start.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top
    import usd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    usd_in_if.sink    in_ch,
    usd_out_if.source out_ch
);

    byte_class_t push_data;
    logic        push_valid;
    logic        push_ready;
    byte_class_t pop_data;
    logic        pop_valid;
    logic        pop_ready;

    usd_front u_front (
        .in_ch      (in_ch),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    usd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    usd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .out_ch    (out_ch)
    );

endmodule

// File: verif/usd_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Watches the byte and character channels, decodes every accepted byte with
// its own model of the decoder and compares each accepted character with the
// oldest one predicted, field by field.
// ----------------------------------------------------------------------------
module usd_checker
    import usd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    usd_in_if    in_ch,
    usd_out_if   out_ch,
    output int   failures,
    output int   waiting,
    output int   bytes_seen,
    output int   ok_chars,
    output int   bad_leads,
    output int   truncations
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CP_WIDTH-1:0]    code_point;
        logic [COUNT_WIDTH-1:0] byte_count;
        logic                   first_in_word;
        status_t                status;
    } decoded_char_t;

    decoded_char_t          expected_chars[$];
    logic [COUNT_WIDTH-1:0] cont_left;
    logic [CP_WIDTH-1:0]    value_acc;
    logic [COUNT_WIDTH-1:0] seq_len;
    logic                   word_start;

    // Sequence length given by a lead byte, 0 when the byte cannot lead.
    function automatic int lead_length(input logic [BYTE_WIDTH-1:0] b,
                                       output logic [6:0] bits);
        bits = '0;
        casez (b)
            8'b0???????: begin bits = b[6:0];          return 1; end
            8'b110?????: begin bits = {2'b00, b[4:0]}; return 2; end
            8'b1110????: begin bits = {3'b000, b[3:0]}; return 3; end
            8'b11110???: begin bits = {4'h0, b[2:0]};  return 4; end
            8'b111110??: begin bits = {5'h00, b[1:0]}; return 5; end
            8'b1111110?: begin bits = {6'h00, b[0]};   return 6; end
            default:     return 0;
        endcase
    endfunction

    task automatic decode_byte(input logic [BYTE_WIDTH-1:0] b);
        decoded_char_t ch;
        logic [6:0]    bits;
        int            len;
        bit            produced;
        produced         = 1'b0;
        ch.code_point    = '0;
        ch.byte_count    = 3'd1;
        ch.first_in_word = word_start;
        ch.status        = ST_OK;
        if (cont_left == 0) begin
            if (b == BYTE_LF || b == BYTE_CR || b == BYTE_NUL) begin
                word_start = 1'b1;
            end
            else begin
                len = lead_length(b, bits);
                if (len == 0) begin
                    ch.status  = ST_BAD_LEAD;
                    produced   = 1'b1;
                    word_start = 1'b0;
                end
                else if (len == 1) begin
                    ch.code_point = CP_WIDTH'(bits);
                    produced      = 1'b1;
                    word_start    = 1'b0;
                end
                else begin
                    value_acc = CP_WIDTH'(bits);
                    seq_len   = COUNT_WIDTH'(len);
                    cont_left = COUNT_WIDTH'(len - 1);
                end
            end
        end
        else if (b == BYTE_LF) begin
            // A line feed inside a sequence drops it and reports what was taken.
            ch.byte_count = seq_len - cont_left;
            ch.status     = ST_TRUNCATED;
            produced      = 1'b1;
            cont_left     = '0;
            value_acc     = '0;
            seq_len       = '0;
            word_start    = 1'b1;
        end
        else begin
            value_acc = {value_acc[CP_WIDTH-7:0], b[5:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == 0) begin
                ch.code_point = value_acc;
                ch.byte_count = seq_len;
                produced      = 1'b1;
                word_start    = 1'b0;
                value_acc     = '0;
                seq_len       = '0;
            end
        end
        if (produced)
            expected_chars.push_back(ch);
    endtask

    always @(posedge clk or negedge rst_n) begin
        decoded_char_t want;
        if (!rst_n) begin
            expected_chars.delete();
            cont_left   = '0;
            value_acc   = '0;
            seq_len     = '0;
            word_start  = 1'b1;
            failures    = 0;
            waiting     = 0;
            bytes_seen  = 0;
            ok_chars    = 0;
            bad_leads   = 0;
            truncations = 0;
        end
        else begin
            if (in_ch.valid && in_ch.ready) begin
                decode_byte(in_ch.data_byte);
                bytes_seen++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_chars.size() == 0) begin
                    failures++;
                    $display("%0t: character with none expected, actual cp %h cnt %0d",
                             $time, out_ch.code_point, out_ch.byte_count);
                end
                else begin
                    want = expected_chars.pop_front();
                    if (out_ch.code_point !== want.code_point) begin
                        failures++;
                        $display("%0t: code_point expected %h actual %h",
                                 $time, want.code_point, out_ch.code_point);
                    end
                    if (out_ch.byte_count !== want.byte_count) begin
                        failures++;
                        $display("%0t: byte_count expected %0d actual %0d",
                                 $time, want.byte_count, out_ch.byte_count);
                    end
                    if (out_ch.first_in_word !== want.first_in_word) begin
                        failures++;
                        $display("%0t: first_in_word expected %b actual %b",
                                 $time, want.first_in_word, out_ch.first_in_word);
                    end
                    if (out_ch.status !== want.status) begin
                        failures++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, out_ch.status);
                    end
                    case (want.status)
                        ST_OK:       ok_chars++;
                        ST_BAD_LEAD: bad_leads++;
                        default:     truncations++;
                    endcase
                end
            end
            waiting = expected_chars.size();
        end
    end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Feeds a directed byte sequence and then random character sequences, mostly
// well formed, into the decoder, with random gaps on both channels and one
// long output hold-off, and lets the checker judge every character.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import usd_pkg::*;

    localparam int RANDOM_BYTES = 2000;
    localparam int MAX_GAP      = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [BYTE_WIDTH-1:0] DIRECTED_BYTES [24] = '{
        BYTE_LF, BYTE_NUL, 8'h7F, 8'h80, 8'hFF, BYTE_CR, 8'hFE,
        8'hC0, BYTE_NUL,
        8'hE1, BYTE_CR, BYTE_LF,
        8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hF8, BYTE_LF,
        8'hF4, 8'h80, 8'h80, 8'h80
    };

    logic clk = 1'b0;
    logic rst_n;
    bit   source_idle_on;
    bit   sink_idle_on;
    bit   hold_request;
    int   holds_done;
    int   bytes_sent;
    int   failures;
    int   chars_waiting;
    int   bytes_seen;
    int   ok_chars;
    int   bad_leads;
    int   truncations;

    usd_in_if  in_ch();
    usd_out_if out_ch();

    utf8_stream_decoder_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    usd_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .failures    (failures),
        .waiting     (chars_waiting),
        .bytes_seen  (bytes_seen),
        .ok_chars    (ok_chars),
        .bad_leads   (bad_leads),
        .truncations (truncations)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Returns at the rising edge that accepts the byte.
    task automatic send_byte(input logic [BYTE_WIDTH-1:0] b);
        int gap;
        gap = source_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        @(negedge clk);
        while (!in_ch.ready) @(negedge clk);
        @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [BYTE_WIDTH-1:0] lead_byte(input int len);
        logic [BYTE_WIDTH-1:0] r;
        r = BYTE_WIDTH'($urandom);
        case (len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            4:       return {5'b11110, r[2:0]};
            5:       return {6'b111110, r[1:0]};
            default: return {7'b1111110, r[0]};
        endcase
    endfunction

    // Mostly a proper 10xxxxxx byte; now and then any byte at all.
    function automatic logic [BYTE_WIDTH-1:0] cont_byte();
        logic [BYTE_WIDTH-1:0] r;
        r = BYTE_WIDTH'($urandom);
        if ($urandom_range(0, 15) == 0)
            return r;
        return {2'b10, r[5:0]};
    endfunction

    initial
    begin
        int pick;
        int len;
        int next_switch;
        bit hold_issued;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        source_idle_on  = 1'b1;
        hold_issued     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i]);

        next_switch = bytes_sent;
        while (bytes_sent < RANDOM_BYTES + $size(DIRECTED_BYTES))
        begin
            if (bytes_sent >= next_switch)
            begin
                next_switch    = bytes_sent + 100;
                source_idle_on = $urandom_range(0, 3) != 0;
                if (!hold_issued && bytes_sent >= RANDOM_BYTES / 2)
                begin
                    // Stop the output for a while and keep bytes coming back to back.
                    hold_issued    = 1'b1;
                    hold_request   = 1'b1;
                    source_idle_on = 1'b0;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                len = $urandom_range(1, 6);
                send_byte(lead_byte(len));
                repeat (len - 1) send_byte(cont_byte());
            end
            else if (pick < 85)
            begin
                case ($urandom_range(0, 2))
                    0:       send_byte(BYTE_LF);
                    1:       send_byte(BYTE_CR);
                    default: send_byte(BYTE_NUL);
                endcase
            end
            else if (pick < 93)
            begin
                len = $urandom_range(2, 6);
                send_byte(lead_byte(len));
                repeat ($urandom_range(0, len - 2)) send_byte({2'b10, 6'($urandom)});
                send_byte(BYTE_LF);
            end
            else
            begin
                send_byte(BYTE_WIDTH'($urandom));
            end
        end
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (chars_waiting != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes, %0d chars: %0d ok, %0d bad leads, %0d cut short.",
                 bytes_seen, ok_chars + bad_leads + truncations, ok_chars, bad_leads,
                 truncations);
        $display("Lengths one to six, line ends in and out of sequences, %0d long stall.",
                 holds_done);
        if (chars_waiting != 0)
            $display("%0t: %0d expected characters never arrived", $time, chars_waiting);
        if (failures == 0 && chars_waiting == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Output side: a random stall before each transaction while sink gaps are on, plus one long hold-off.
    initial
    begin
        int stall;
        int taken;
        bit hold_served;
        out_ch.ready <= 1'b0;
        sink_idle_on = 1'b1;
        taken        = 0;
        holds_done   = 0;
        hold_served  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_served)
            begin
                hold_served = 1'b1;
                stall       = HOLD_CYCLES;
                holds_done++;
            end
            else
            begin
                stall = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(negedge clk);
            while (!out_ch.valid) @(negedge clk);
            @(posedge clk);
            taken++;
            if (taken % 50 == 0)
                sink_idle_on = $urandom_range(0, 3) != 0;
        end
    end

    initial
    begin
        #10_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("testbench NOT OK");
        $finish;
    end

endmodule
